/* src/ffea_pkg.sv */
// Shared types and constants of the first-fit extent allocator.
package ffea_pkg;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  localparam logic [31:0] REGION_RESET = 32'd33554432;

endpackage

/* src/first_fit_extent_allocator.sv */
// Top level of the first-fit extent allocator with its extent table memory.
//
//  channel | direction | handshake     | payload
//  in_     | input     | valid / stall | operation, block_size, align_log2, block_offset
//  out_    | output    | valid / stall | status, granted_offset
//  cfg_    | input     | valid / ready | data (region_size)
//
// A request reads the table one entry at a time (read, then evaluate),
// until the first fitting or following extent is found; a removal or insertion
// then shifts the tail of the table one entry at a time through the memory.
// Walk and shift together cover the table once, and the result beat can then be stalled.
// Reset and a configuration write set the table to one extent (none for a zero size):
// entries at or above the count are never used, so no clearing pass is needed.
// The result sits in an output register; a new beat is taken only after it
// has been delivered.
module first_fit_extent_allocator
  import ffea_pkg::*;
#(
  parameter int MAX_EXTENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_block_size,
  input  logic [4:0]  in_align_log2,
  input  logic [31:0] in_block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_EXTENTS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EVAL, S_FREE_PREV, S_FREE_DEC,
    S_SH_RD, S_SH_WR, S_INS_RD, S_INS_WR, S_OUT
  } state_t;

  state_t state_r;
  logic [63:0] mem_r [MAX_EXTENTS];
  logic [63:0] rd_q_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;

  logic [CW-1:0] count_r, idx_r, k_r;
  logic        op_r;
  logic [31:0] size_r, off_r, mask_r;
  logic [31:0] ps_r, pl_r;       // previous extent for free
  logic        has_prev_r;
  logic [63:0] carry_r;          // entry being pushed up during insert
  logic [CW-1:0] ins_end_r;
  logic [1:0]  status_r;
  logic [31:0] granted_r;

  // Shared evaluation of the entry just read.
  logic [32:0] s, l, a, pad, sz;
  logic [33:0] tail, pend, endf;
  logic fits;
  always_comb begin
    s    = {1'b0, rd_q_r[63:32]};
    l    = {1'b0, rd_q_r[31:0]};
    sz   = {1'b0, size_r};
    a    = (s + {1'b0, mask_r}) & ~{1'b0, mask_r};
    pad  = a - s;
    fits = !a[32] && pad <= l && (l - pad) >= sz;
    tail = {1'b0, l - pad - sz};
    pend = {2'b0, ps_r} + {2'b0, pl_r};
    endf = {2'b0, off_r} + {2'b0, size_r};
  end

  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = status_r;
  assign out_granted_offset = granted_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rd_q_r <= mem_r[raddr];
  end

  always_comb begin
    we = 1'b0; waddr = idx_r[AW-1:0]; wdata = rd_q_r;
    raddr = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          we = 1'b1; waddr = '0; wdata = {32'd0, cfg_data};
        end
        raddr = '0;
      end
      S_SH_RD:  raddr = AW'(k_r + 1'b1);
      S_SH_WR:  begin we = 1'b1; waddr = k_r[AW-1:0]; wdata = rd_q_r; end
      S_INS_RD: raddr = k_r[AW-1:0];
      S_INS_WR: begin we = 1'b1; waddr = k_r[AW-1:0]; wdata = carry_r; end
      S_EVAL: begin
        if (op_r == OP_ALLOC && idx_r < count_r && fits) begin
          if (pad == '0 && tail != '0) begin
            we = 1'b1; wdata = {a[31:0] + size_r, tail[31:0]};
          end else if (pad != '0 && (tail == '0 || count_r < CMAX)) begin
            we = 1'b1; wdata = {rd_q_r[63:32], pad[31:0]};
          end
        end else if (op_r == OP_FREE && idx_r < count_r && !({1'b0, rd_q_r[63:32]} < {1'b0, off_r})) begin
          // Next neighbor found; a lone join-next is written here.
          if (!(has_prev_r && pend[32:0] > {1'b0, off_r}) && endf <= {2'b0, s}
              && endf == {2'b0, s} && !(has_prev_r && pend[32:0] == {1'b0, off_r})) begin
            we = 1'b1; wdata = {off_r, rd_q_r[31:0] + size_r};
          end
        end
      end
      S_FREE_PREV: begin we = 1'b1; waddr = AW'(idx_r - 1'b1); wdata = {ps_r, pl_r}; end
      default: ;
    endcase
    // While reset is held, entry 0 is loaded with the whole reset region.
    if (!rst_n) begin
      we = 1'b1; waddr = '0; wdata = {32'd0, REGION_RESET};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(1);
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            count_r <= (cfg_data != '0) ? CW'(1) : '0;
          end else if (in_valid) begin
            op_r   <= in_operation;
            size_r <= in_block_size;
            off_r  <= in_block_offset;
            mask_r <= (32'd1 << in_align_log2) - 32'd1;
            idx_r  <= '0;
            has_prev_r <= 1'b0;
            status_r <= ST_DONE; granted_r <= '0;
            if (in_operation == OP_ALLOC && in_block_size == '0) begin
              status_r <= ST_NOFIT; state_r <= S_OUT;
            end else if (in_operation == OP_FREE &&
                         ({1'b0, in_block_offset} + {1'b0, in_block_size} > 33'hFFFFFFFF
                          || in_block_size == '0)) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_EVAL;
            end
          end
        end
        S_RD: state_r <= S_EVAL;
        S_EVAL: begin
          if (op_r == OP_ALLOC) begin
            if (idx_r >= count_r) begin
              status_r <= ST_NOFIT; state_r <= S_OUT;
            end else if (!fits) begin
              idx_r <= idx_r + 1'b1; state_r <= S_RD;
            end else if (pad != '0 && tail != '0 && count_r >= CMAX) begin
              status_r <= ST_FULL; state_r <= S_OUT;
            end else begin
              granted_r <= a[31:0];
              if (pad == '0 && tail == '0) begin
                k_r <= idx_r; state_r <= S_FREE_DEC;
              end else if (pad != '0 && tail != '0) begin
                carry_r <= {a[31:0] + size_r, tail[31:0]};
                k_r <= idx_r + 1'b1; ins_end_r <= count_r;
                count_r <= count_r + 1'b1; state_r <= S_INS_RD;
              end else begin
                state_r <= S_OUT;
              end
            end
          end else begin
            if (idx_r < count_r && {1'b0, rd_q_r[63:32]} < {1'b0, off_r}) begin
              ps_r <= rd_q_r[63:32]; pl_r <= rd_q_r[31:0]; has_prev_r <= 1'b1;
              idx_r <= idx_r + 1'b1; state_r <= S_RD;
            end else begin
              logic nxt, jp, jn;
              nxt = idx_r < count_r;
              jp  = has_prev_r && pend[32:0] == {1'b0, off_r};
              jn  = nxt && endf == {2'b0, s};
              if ((has_prev_r && pend[32:0] > {1'b0, off_r}) || (nxt && endf > {2'b0, s})) begin
                state_r <= S_OUT;
              end else if (jp && jn) begin
                pl_r <= pl_r + size_r + rd_q_r[31:0];
                k_r <= idx_r; state_r <= S_FREE_PREV;
              end else if (jp) begin
                pl_r <= pl_r + size_r; k_r <= count_r; state_r <= S_FREE_PREV;
              end else if (jn) begin
                state_r <= S_OUT;
              end else if (count_r >= CMAX) begin
                status_r <= ST_FULL; state_r <= S_OUT;
              end else begin
                carry_r <= {off_r, size_r}; k_r <= idx_r;
                ins_end_r <= count_r; count_r <= count_r + 1'b1;
                state_r <= S_INS_RD;
              end
            end
          end
        end
        S_FREE_PREV: state_r <= (k_r == count_r) ? S_OUT : S_FREE_DEC;
        S_FREE_DEC: state_r <= S_SH_RD;  // k_r is the entry to remove
        S_SH_RD: begin
          if (k_r + 1'b1 >= count_r) begin
            count_r <= count_r - 1'b1; state_r <= S_OUT;
          end else begin
            state_r <= S_SH_WR;
          end
        end
        S_SH_WR: begin k_r <= k_r + 1'b1; state_r <= S_SH_RD; end
        S_INS_RD: state_r <= S_INS_WR;
        S_INS_WR: begin
          carry_r <= rd_q_r;
          if (k_r >= ins_end_r) state_r <= S_OUT;
          else begin k_r <= k_r + 1'b1; state_r <= S_INS_RD; end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CMAX)
    else $error("extent count above table depth");
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_granted_offset == '0)
    else $error("nonzero offset with failing status");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
`endif

endmodule

/* verif/tb_first_fit_extent_allocator.sv */
// Self-checking testbench for the first-fit extent allocator with a free-list predictor.
module tb_first_fit_extent_allocator;
  import ffea_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam longint unsigned WORD_TOP = 64'hFFFF_FFFF;

  class extent_scoreboard;
    logic [31:0] ext_start[TABLE_DEPTH];
    logic [31:0] ext_len[TABLE_DEPTH];
    int unsigned ext_count;
    status_t exp_status[$];
    logic [31:0] exp_offset[$];
    logic [31:0] live_off[$];
    logic [31:0] live_len[$];
    int errors;

    function new();
      errors = 0;
      set_region(REGION_RESET);
    endfunction

    function void set_region(logic [31:0] bytes);
      ext_start[0] = '0;
      ext_len[0] = bytes;
      ext_count = (bytes != 0) ? 1 : 0;
      live_off.delete();
      live_len.delete();
    endfunction

    function void remove_at(int unsigned idx);
      for (int unsigned k = idx; k + 1 < ext_count; k++) begin
        ext_start[k] = ext_start[k + 1];
        ext_len[k] = ext_len[k + 1];
      end
      ext_count--;
    endfunction

    function void insert_at(int unsigned idx, logic [31:0] s, logic [31:0] l);
      for (int unsigned k = ext_count; k > idx; k--) begin
        ext_start[k] = ext_start[k - 1];
        ext_len[k] = ext_len[k - 1];
      end
      ext_start[idx] = s;
      ext_len[idx] = l;
      ext_count++;
    endfunction

    function status_t grant(longint unsigned sz, int unsigned alog, output logic [31:0] g);
      longint unsigned mask, s, l, a, head, tail;
      mask = (64'd1 << alog) - 1;
      g = '0;
      if (sz == 0) return ST_NOFIT;
      for (int unsigned i = 0; i < ext_count; i++) begin
        s = ext_start[i];
        l = ext_len[i];
        a = (s + mask) & ~mask;
        head = a - s;
        if (a > WORD_TOP || head > l || l - head < sz) continue;
        tail = l - head - sz;
        if (head == 0 && tail == 0) begin
          remove_at(i);
        end else if (head == 0) begin
          ext_start[i] = 32'(a + sz);
          ext_len[i] = 32'(tail);
        end else if (tail == 0) begin
          ext_len[i] = 32'(head);
        end else begin
          // The split needs a fresh entry; a full table refuses it outright.
          if (ext_count >= TABLE_DEPTH) return ST_FULL;
          ext_len[i] = 32'(head);
          insert_at(i + 1, 32'(a + sz), 32'(tail));
        end
        g = 32'(a);
        return ST_DONE;
      end
      return ST_NOFIT;
    endfunction

    function status_t release_block(longint unsigned off, longint unsigned sz);
      longint unsigned fin, pend;
      int unsigned i;
      bit join_prev, join_next;
      fin = off + sz;
      i = 0;
      join_prev = 0;
      join_next = 0;
      if (sz == 0 || fin > WORD_TOP) return ST_DONE;
      while (i < ext_count && longint'(ext_start[i]) < off) i++;
      if (i > 0) begin
        pend = longint'(ext_start[i - 1]) + ext_len[i - 1];
        if (pend > off) return ST_DONE;
        join_prev = (pend == off);
      end
      if (i < ext_count) begin
        if (fin > ext_start[i]) return ST_DONE;
        join_next = (fin == ext_start[i]);
      end
      if (join_prev && join_next) begin
        ext_len[i - 1] = 32'(ext_len[i - 1] + sz + ext_len[i]);
        remove_at(i);
      end else if (join_prev) begin
        ext_len[i - 1] = 32'(ext_len[i - 1] + sz);
      end else if (join_next) begin
        ext_start[i] = 32'(off);
        ext_len[i] = 32'(ext_len[i] + sz);
      end else begin
        if (ext_count >= TABLE_DEPTH) return ST_FULL;
        insert_at(i, 32'(off), 32'(sz));
      end
      return ST_DONE;
    endfunction

    function void note_request(op_t op, logic [31:0] sz, logic [4:0] alog, logic [31:0] off,
                               bit tracked);
      status_t st;
      logic [31:0] g;
      g = '0;
      if (op == OP_ALLOC) begin
        st = grant(sz, alog, g);
        if (st == ST_DONE) begin
          live_off.push_back(g);
          live_len.push_back(sz);
        end
      end else begin
        st = release_block(off, sz);
        // A tracked block that could not be returned stays allocated.
        if (tracked && st != ST_DONE) begin
          live_off.push_back(off);
          live_len.push_back(sz);
        end
      end
      exp_status.push_back(st);
      exp_offset.push_back(g);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [31:0] g);
      status_t want_st;
      logic [31:0] want_g;
      if (exp_status.size() == 0) begin
        report($sformatf("unexpected beat status=%0d offset=%h", st, g));
        return;
      end
      want_st = exp_status.pop_front();
      want_g = exp_offset.pop_front();
      if (st !== want_st)
        report($sformatf("status %0d, expected %0d", st, want_st));
      if (g !== want_g)
        report($sformatf("granted_offset %h, expected %h", g, want_g));
    endtask

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [31:0] in_block_size = '0;
  logic [4:0]  in_align_log2 = '0;
  logic [31:0] in_block_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_granted_offset;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  extent_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  logic [31:0] size_cap = 64;
  logic [31:0] last_off = '0;
  logic [31:0] last_len = 1;

  first_fit_extent_allocator uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check accepted beats, then choose the stall for the next edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_granted_offset);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(op_t op, logic [31:0] sz, logic [4:0] alog, logic [31:0] off,
                              bit tracked = 0);
    int gap;
    gap = 0;
    in_operation <= op;
    in_block_size <= sz;
    in_align_log2 <= alog;
    in_block_offset <= off;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, sz, alog, off, tracked);
    while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_region(logic [31:0] bytes);
    drain();
    cfg_data <= bytes;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_region(bytes);
  endtask

  function automatic logic [4:0] pick_align();
    return ($urandom_range(9) < 8) ? 5'($urandom_range(6)) : 5'($urandom_range(31));
  endfunction

  task automatic random_request();
    int r, idx;
    logic [31:0] o, l;
    r = $urandom_range(99);
    if (r < 50 || sb.live_off.size() == 0 && r < 88) begin
      l = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(size_cap, 1);
      send_request(OP_ALLOC, l, pick_align(), $urandom());
    end else if (r < 88) begin
      idx = $urandom_range(sb.live_off.size() - 1);
      o = sb.live_off[idx];
      l = sb.live_len[idx];
      sb.live_off.delete(idx);
      sb.live_len.delete(idx);
      last_off = o;
      last_len = l;
      send_request(OP_FREE, l, 5'($urandom()), o, 1);
    end else begin
      case ($urandom_range(3))
        0: send_request(OP_FREE, last_len, 5'($urandom()), last_off);
        1: send_request(OP_FREE, 0, 5'($urandom()), $urandom());
        2: send_request(OP_FREE, $urandom(), 5'($urandom()), $urandom());
        default: send_request(OP_FREE, $urandom_range(size_cap, 1), 5'($urandom()),
                              $urandom_range(size_cap * 4, 0));
      endcase
    end
  endtask

  initial begin
    logic [31:0] regions[6];
    logic [31:0] caps[6];
    regions = '{32'd4096, 32'hFFFF_FFFF, 32'd1, 32'd65536, 32'd4096, REGION_RESET};
    caps = '{32'd64, 32'h00FF_FFFF, 32'd1, 32'd512, 32'd48, 32'd4096};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset region.
    send_request(OP_ALLOC, 0, 5'd0, 0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 5'd0, 0);
    send_request(OP_ALLOC, 1, 5'd31, 0);
    send_request(OP_ALLOC, 16, 5'd4, 0);
    send_request(OP_ALLOC, 100, 5'd31, 0);
    send_request(OP_FREE, 0, 5'd0, 32'h40);
    send_request(OP_FREE, 32'h20, 5'd0, 32'hFFFF_FFF0);
    send_request(OP_FREE, 10, 5'd0, 32'h100);
    send_request(OP_FREE, 1, 5'd0, 0);
    send_request(OP_FREE, 1, 5'd0, 0);
    send_request(OP_FREE, 16, 5'd0, 16);
    // An empty table refuses every allocate; frees still rebuild it.
    write_region(0);
    send_request(OP_ALLOC, 1, 5'd0, 0);
    send_request(OP_FREE, 8, 5'd0, 32'h10);
    send_request(OP_FREE, 8, 5'd0, 32'h18);
    send_request(OP_FREE, 8, 5'd0, 32'h40);
    send_request(OP_ALLOC, 8, 5'd3, 0);
    // Full 32-bit region: an aligned start past the top does not fit.
    write_region(32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'h8000_0001, 5'd0, 0);
    send_request(OP_ALLOC, 1, 5'd31, 0);
    send_request(OP_ALLOC, 32'h7FFF_FFFE, 5'd0, 0);
    send_request(OP_FREE, 32'h8000_0001, 5'd0, 0);
    send_request(OP_ALLOC, 32'h8000_0000, 5'd31, 0);

    for (int p = 0; p < 6; p++) begin
      write_region(regions[p]);
      size_cap = caps[p];
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 73; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 73; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      if (p == 0) hold_left = 2000;
      for (int n = 0; n < 72; n++) random_request();
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ffea_pkg.sv
src/first_fit_extent_allocator.sv
verif/tb_first_fit_extent_allocator.sv
